>>> hdl/atou_pkg.sv
// shared types and constants for the ascii to unsigned parser
`default_nettype none

package atou_pkg;

  localparam int WORD_BITS   = 32;
  localparam int OFFSET_BITS = 12;
  localparam int CHAR_BITS   = 8;
  localparam int BASE_BITS   = 6;
  localparam int DIGIT_BITS  = 6;

  localparam int OUT_FIELD_BITS = WORD_BITS + 2 + OFFSET_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_FIELD_BITS;

  localparam logic [BASE_BITS-1:0]   BASE_RESET = BASE_BITS'(10);
  localparam logic [BASE_BITS-1:0]   BASE_DEC   = BASE_BITS'(10);
  localparam logic [BASE_BITS-1:0]   BASE_OCT   = BASE_BITS'(8);
  localparam logic [BASE_BITS-1:0]   BASE_HEX   = BASE_BITS'(16);
  localparam logic [BASE_BITS-1:0]   BASE_AUTO  = '0;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX   = '1;
  localparam logic [WORD_BITS-1:0]   SAT_VALUE = {1'b0, {(WORD_BITS-1){1'b1}}};

  // character codes
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_BITS-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5a;
  localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7a;
  localparam logic [CHAR_BITS-1:0] CH_UPPER_BIAS = CH_UA - 8'd10;
  localparam logic [CHAR_BITS-1:0] CH_LOWER_BIAS = CH_LA - 8'd10;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WS,
    PH_SIGN,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  typedef struct packed {
    logic                 ok;
    logic                 ovf;
    logic [WORD_BITS-1:0] acc;
  } digit_res_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] end_offset;
    logic                   digits_seen;
    logic                   overflowed;
    logic [WORD_BITS-1:0]   value;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/atou_digit.sv
// digit decode and multiply-accumulate with overflow detection
`default_nettype none

module atou_digit import atou_pkg::*; (
  input  logic [CHAR_BITS-1:0] char_in,
  input  logic [BASE_BITS-1:0] base_in,
  input  logic [WORD_BITS-1:0] acc_in,
  input  logic                 ovf_in,
  output digit_res_t           res
);

  logic [DIGIT_BITS-1:0]          digit;
  logic                           is_digit;
  logic [BASE_BITS-1:0]           base_eff;
  logic [WORD_BITS+BASE_BITS-1:0] prod;
  logic [WORD_BITS+BASE_BITS:0]   sum;
  logic                           wraps;

  always_comb begin
    digit    = '0;
    is_digit = 1'b1;
    if (char_in inside {[CH_0:CH_9]}) begin
      digit = DIGIT_BITS'(char_in - CH_0);
    end else if (char_in inside {[CH_UA:CH_UZ]}) begin
      digit = DIGIT_BITS'(char_in - CH_UPPER_BIAS);
    end else if (char_in inside {[CH_LA:CH_LZ]}) begin
      digit = DIGIT_BITS'(char_in - CH_LOWER_BIAS);
    end else begin
      is_digit = 1'b0;
    end
  end

  assign base_eff = (base_in == BASE_AUTO) ? BASE_BITS'(1) : base_in;

  // acc*base+d above the word range is the same test as the cutoff compare
  assign prod  = {{BASE_BITS{1'b0}}, acc_in} * {{WORD_BITS{1'b0}}, base_eff};
  assign sum   = {1'b0, prod} + (WORD_BITS+BASE_BITS+1)'(digit);
  assign wraps = |sum[WORD_BITS+BASE_BITS:WORD_BITS];

  always_comb begin
    res.ok  = is_digit && (BASE_BITS'(digit) < base_eff);
    res.ovf = ovf_in || wraps;
    res.acc = res.ovf ? acc_in : sum[WORD_BITS-1:0];
  end

endmodule

`default_nettype wire

>>> hdl/atou_core.sv
// parse state machine: one character per step, at most one result
`default_nettype none

module atou_core import atou_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [CHAR_BITS-1:0] char_in,
  input  logic                 start_in,
  input  logic [BASE_BITS-1:0] cfg_base,
  output logic                 res_valid,
  output result_t              res
);

  phase_t                 phase_r, phase_nxt, ph_pre;
  logic [WORD_BITS-1:0]   acc_r, acc_nxt, acc_pre;
  logic [BASE_BITS-1:0]   base_r, base_nxt, base_pre, base_dig;
  logic                   neg_r, neg_nxt, neg_pre;
  logic                   ovf_r, ovf_nxt, ovf_pre;
  logic                   any_r, any_nxt, any_pre;
  logic [OFFSET_BITS-1:0] off_r, off_nxt, off_pre;
  logic                   live;
  digit_res_t             dig;

  // state as seen by the character: fresh on a start, offset advanced otherwise
  always_comb begin
    ph_pre   = phase_r;
    acc_pre  = acc_r;
    base_pre = base_r;
    neg_pre  = neg_r;
    ovf_pre  = ovf_r;
    any_pre  = any_r;
    off_pre  = off_r;
    live     = 1'b0;
    if (step) begin
      if (start_in) begin
        ph_pre   = PH_WS;
        acc_pre  = '0;
        base_pre = cfg_base;
        neg_pre  = 1'b0;
        ovf_pre  = 1'b0;
        any_pre  = 1'b0;
        off_pre  = '0;
        live     = 1'b1;
      end else if (phase_r != PH_IDLE) begin
        live = 1'b1;
        if (off_r != OFF_MAX) begin
          off_pre = off_r + OFFSET_BITS'(1);
        end
      end
    end
  end

  // automatic base resolves to octal after a leading zero, decimal otherwise
  assign base_dig = (base_pre != BASE_AUTO) ? base_pre :
                    (ph_pre == PH_ZERO)     ? BASE_OCT : BASE_DEC;

  atou_digit u_digit (
    .char_in (char_in),
    .base_in (base_dig),
    .acc_in  (acc_pre),
    .ovf_in  (ovf_pre),
    .res     (dig)
  );

  always_comb begin
    logic first;
    logic take_dig;
    logic consumed;
    first     = 1'b0;
    take_dig  = 1'b0;
    consumed  = 1'b0;
    phase_nxt = ph_pre;
    acc_nxt   = acc_pre;
    base_nxt  = base_pre;
    neg_nxt   = neg_pre;
    ovf_nxt   = ovf_pre;
    any_nxt   = any_pre;
    off_nxt   = off_pre;
    res_valid = 1'b0;
    res       = '0;

    if (live) begin
      case (ph_pre)
        PH_WS: begin
          if (char_in == CH_SPACE || char_in inside {[CH_TAB:CH_CR]}) begin
            consumed = 1'b1;
          end else if (char_in == CH_MINUS) begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_SIGN;
            consumed  = 1'b1;
          end else if (char_in == CH_PLUS) begin
            phase_nxt = PH_SIGN;
            consumed  = 1'b1;
          end else begin
            first = 1'b1;
          end
        end
        PH_SIGN: begin
          first = 1'b1;
        end
        PH_ZERO: begin
          phase_nxt = PH_DIGITS;
          if (char_in == CH_LX || char_in == CH_UX) begin
            base_nxt = BASE_HEX;
            consumed = 1'b1;
          end else begin
            // the held zero counts as a digit
            base_nxt = base_dig;
            any_nxt  = 1'b1;
            take_dig = 1'b1;
          end
        end
        PH_DIGITS: begin
          take_dig = 1'b1;
        end
        default: begin
          consumed = 1'b1;
        end
      endcase

      if (first) begin
        if ((base_pre == BASE_AUTO || base_pre == BASE_HEX) && char_in == CH_0) begin
          phase_nxt = PH_ZERO;
          consumed  = 1'b1;
        end else begin
          base_nxt  = base_dig;
          phase_nxt = PH_DIGITS;
          take_dig  = 1'b1;
        end
      end

      if (take_dig) begin
        consumed = dig.ok;
        if (dig.ok) begin
          acc_nxt = dig.acc;
          ovf_nxt = dig.ovf;
          any_nxt = 1'b1;
        end
      end

      if (!consumed) begin
        res_valid       = 1'b1;
        phase_nxt       = PH_IDLE;
        res.overflowed  = ovf_nxt;
        res.digits_seen = any_nxt;
        res.end_offset  = any_nxt ? off_nxt : '0;
        res.value       = ovf_nxt ? SAT_VALUE :
                          neg_nxt ? (~acc_nxt + WORD_BITS'(1)) : acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      base_r  <= BASE_RESET;
      neg_r   <= 1'b0;
      ovf_r   <= 1'b0;
      any_r   <= 1'b0;
      off_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      base_r  <= base_nxt;
      neg_r   <= neg_nxt;
      ovf_r   <= ovf_nxt;
      any_r   <= any_nxt;
      off_r   <= off_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/ascii_to_unsigned_parser.sv
// top level: input register, parse core, result register and base register
// a terminating character passes the input register and the parse core into the result register
// throughput: one character per cycle when not stalled (combinational multiply-add)
// the input stage stalls only while a result waits in the output register
// reset: rst_n synchronous active low; clears valids, parse state, base back to 10
`default_nettype none

module ascii_to_unsigned_parser import atou_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [CHAR_BITS-1:0]      in_tdata,   // [7:0] character
  input  logic                      in_tuser,   // [0] string_start
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [31:0] value, [32] overflowed, [33] digits_seen, [45:34] end_offset, rest zero
  output logic [OUT_TDATA_BITS-1:0] out_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [BASE_BITS-1:0]      cfg_data    // number_base
);

  logic                 s1_valid_r;
  logic [CHAR_BITS-1:0] s1_char_r;
  logic                 s1_start_r;
  logic [BASE_BITS-1:0] base_cfg_r;
  logic                 out_valid_r;
  result_t              out_res_r;
  logic                 go;
  logic                 in_acc;
  logic                 res_valid;
  result_t              res;

  assign go        = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || go;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_cfg_r <= BASE_RESET;
    end else if (cfg_valid) begin
      base_cfg_r <= cfg_data;
    end
  end

  atou_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_valid_r && go),
    .char_in   (s1_char_r),
    .start_in  (s1_start_r),
    .cfg_base  (base_cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_BITS{1'b0}}, out_res_r};

endmodule

`default_nettype wire

>>> test/atou_result_checker.sv
// result checker for the ascii to unsigned parser: predicts every conversion and compares outputs
`timescale 1ns / 1ps

module atou_result_checker import atou_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [CHAR_BITS-1:0]      in_tdata,   // [7:0] character
  input  logic                      in_tuser,   // [0] string_start
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  // [31:0] value, [32] overflowed, [33] digits_seen, [45:34] end_offset, rest zero
  input  logic [OUT_TDATA_BITS-1:0] out_tdata,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [BASE_BITS-1:0]      cfg_data,   // number_base
  output int                        fail_count,
  output int                        pending_count
);

  localparam longint unsigned WORD_MASK = (64'd1 << WORD_BITS) - 64'd1;

  // shadow copy of the parser state
  logic [BASE_BITS-1:0]   base_reg;
  logic [BASE_BITS-1:0]   cur_base;
  logic [WORD_BITS-1:0]   acc;
  phase_t                 phase;
  logic                   neg_flag;
  logic                   ovf_flag;
  logic                   any_digit;
  logic [OFFSET_BITS-1:0] char_pos;

  result_t expected_results[$];

  task automatic clear_parse_state();
    base_reg  = BASE_RESET;
    cur_base  = BASE_RESET;
    acc       = '0;
    phase     = PH_IDLE;
    neg_flag  = 1'b0;
    ovf_flag  = 1'b0;
    any_digit = 1'b0;
    char_pos  = '0;
  endtask

  task automatic take_digit(input logic [CHAR_BITS-1:0] c, output bit taken);
    longint unsigned d, radix, cutoff, cutlim;
    bit is_digit;
    is_digit = 1'b1;
    d = 0;
    if (c >= 8'h80) is_digit = 1'b0;
    else if (c >= CH_0 && c <= CH_9) d = c - CH_0;
    else if (c >= CH_UA && c <= CH_UZ) d = c - CH_UPPER_BIAS;
    else if (c >= CH_LA && c <= CH_LZ) d = c - CH_LOWER_BIAS;
    else is_digit = 1'b0;
    radix = (cur_base == BASE_AUTO) ? 1 : cur_base;
    taken = 1'b0;
    if (is_digit && d < radix) begin
      cutoff = WORD_MASK / radix;
      cutlim = WORD_MASK % radix;
      if (ovf_flag || acc > cutoff || (acc == cutoff && d > cutlim)) ovf_flag = 1'b1;
      else acc = WORD_BITS'(acc * radix + d);
      any_digit = 1'b1;
      taken     = 1'b1;
    end
  endtask

  // first character after whitespace and sign
  task automatic take_first(input logic [CHAR_BITS-1:0] c, output bit taken);
    if ((cur_base == BASE_AUTO || cur_base == BASE_HEX) && c == CH_0) begin
      phase = PH_ZERO;
      taken = 1'b1;
    end else begin
      if (cur_base == BASE_AUTO) cur_base = BASE_DEC;
      phase = PH_DIGITS;
      take_digit(c, taken);
    end
  endtask

  task automatic take_char(input logic [CHAR_BITS-1:0] c, output bit taken);
    bit dummy;
    case (phase)
      PH_WS: begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          taken = 1'b1;
        end else if (c == CH_MINUS) begin
          neg_flag = 1'b1;
          phase    = PH_SIGN;
          taken    = 1'b1;
        end else if (c == CH_PLUS) begin
          phase = PH_SIGN;
          taken = 1'b1;
        end else begin
          take_first(c, taken);
        end
      end
      PH_SIGN: take_first(c, taken);
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          cur_base = BASE_HEX;
          phase    = PH_DIGITS;
          taken    = 1'b1;
        end else begin
          if (cur_base == BASE_AUTO) cur_base = BASE_OCT;
          phase = PH_DIGITS;
          // the held leading zero counts as a digit once the radix is known
          take_digit(CH_0, dummy);
          take_digit(c, taken);
        end
      end
      default: take_digit(c, taken);
    endcase
  endtask

  task automatic parse_char(input logic [CHAR_BITS-1:0] c, input logic start);
    bit taken;
    result_t r;
    if (start) begin
      acc       = '0;
      phase     = PH_WS;
      cur_base  = base_reg;
      neg_flag  = 1'b0;
      ovf_flag  = 1'b0;
      any_digit = 1'b0;
      char_pos  = '0;
    end else if (phase == PH_IDLE) begin
      return;
    end else if (char_pos < OFF_MAX) begin
      char_pos++;
    end
    take_char(c, taken);
    if (!taken) begin
      if (ovf_flag) r.value = SAT_VALUE;
      else if (neg_flag) r.value = -acc;
      else r.value = acc;
      r.overflowed  = ovf_flag;
      r.digits_seen = any_digit;
      r.end_offset  = any_digit ? char_pos : '0;
      expected_results.push_back(r);
      phase = PH_IDLE;
    end
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch in %s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want, got;
    if (!rst_n) begin
      clear_parse_state();
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[OUT_FIELD_BITS-1:0];
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transaction: 0x%0h", out_tdata);
        end else begin
          want = expected_results.pop_front();
          check_field("value", want.value, got.value);
          check_field("overflowed", want.overflowed, got.overflowed);
          check_field("digits_seen", want.digits_seen, got.digits_seen);
          check_field("end_offset", want.end_offset, got.end_offset);
          check_field("padding", 0, out_tdata[OUT_TDATA_BITS-1:OUT_FIELD_BITS]);
        end
      end
      if (cfg_valid && cfg_ready) base_reg = cfg_data;
      if (in_tvalid && in_tready) parse_char(in_tdata, in_tuser);
    end
    pending_count = expected_results.size();
  end

endmodule

>>> test/testbench.sv
// top of the ascii to unsigned parser testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
  import atou_pkg::*;

  localparam int RANDOM_CHARS = 1000;
  localparam int CALM_CHARS   = 880;
  localparam int LONG_DIGITS  = 40;
  localparam int HOLD_CYCLES  = 200;
  localparam logic [CHAR_BITS-1:0] CH_NUL = 8'h00;

  logic                      clk;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [CHAR_BITS-1:0]      in_tdata;
  logic                      in_tuser;
  logic                      out_tvalid;
  logic                      out_tready;
  logic [OUT_TDATA_BITS-1:0] out_tdata;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [BASE_BITS-1:0]      cfg_data;

  int fail_count;
  int pending_count;

  int                   chars_sent;
  int                   rand_begin;
  bit                   calm;
  bit                   long_stall_req;
  bit                   at_start;
  logic [BASE_BITS-1:0] base_now;

  ascii_to_unsigned_parser u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  atou_result_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("ascii_to_unsigned_parser test failed");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_char(input logic [CHAR_BITS-1:0] c, input logic start);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic put_char(input logic [CHAR_BITS-1:0] c);
    send_char(c, at_start);
    at_start = 1'b0;
  endtask

  task automatic send_text(input string s);
    at_start = 1'b1;
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  // only while nothing is in flight; items without a result may still be in the pipe
  task automatic write_base(input logic [BASE_BITS-1:0] b);
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= b;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    base_now = b;
  endtask

  function automatic logic [CHAR_BITS-1:0] digit_char(input int d);
    if (d < 10) return CH_0 + 8'(d);
    return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(d - 10);
  endfunction

  function automatic logic [BASE_BITS-1:0] pick_base(input int k);
    case (k)
      0:       return BASE_AUTO;
      1:       return 6'd1;
      2:       return 6'd2;
      3:       return BASE_OCT;
      4:       return BASE_DEC;
      5:       return BASE_HEX;
      6:       return 6'd36;
      7:       return 6'd37;
      default: return 6'd63;
    endcase
  endfunction

  // mostly well-formed numbers with random content, some noise and broken strings
  task automatic send_number();
    int radix, dig_lim, ndig, sel;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6))
        send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      return;
    end
    at_start = 1'b1;
    repeat ($urandom_range(0, 2))
      put_char($urandom_range(0, 5) == 0 ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4)));
    sel = $urandom_range(0, 3);
    if (sel == 0) put_char(CH_MINUS);
    else if (sel == 1) put_char(CH_PLUS);
    radix = base_now;
    if (base_now == BASE_AUTO) begin
      sel = $urandom_range(0, 2);
      if (sel == 0) begin
        put_char(CH_0);
        put_char($urandom_range(0, 1) ? CH_LX : CH_UX);
        radix = 16;
      end else if (sel == 1) begin
        put_char(CH_0);
        radix = 8;
      end else begin
        put_char(digit_char($urandom_range(1, 9)));
        radix = 10;
      end
    end else if (base_now == BASE_HEX && $urandom_range(0, 1)) begin
      put_char(CH_0);
      put_char($urandom_range(0, 1) ? CH_LX : CH_UX);
    end
    dig_lim = (radix > 36) ? 36 : radix;
    ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 34) : $urandom_range(0, 7);
    repeat (ndig) put_char(digit_char($urandom_range(0, dig_lim - 1)));
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: put_char(CH_NUL);
      4:          put_char(CH_SPACE);
      5:          put_char(8'($urandom_range(8'h80, 8'hff)));
      6:          put_char(8'($urandom_range(8'h21, 8'h2f)));
      7:          put_char(radix < 36 ? digit_char(radix) : 8'h40);
      8:          ; // left open, the next start drops it
      default:    put_char(8'($urandom_range(0, 255)));
    endcase
    // stray bytes after the end of a string
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) send_char(8'($urandom_range(0, 255)), 1'b0);
  endtask

  initial begin
    int k, phase_end;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    chars_sent     = 0;
    calm           = 1'b0;
    long_stall_req = 1'b0;
    at_start       = 1'b0;
    base_now       = BASE_RESET;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed strings in the reset base
    send_text("4294967296");
    put_char(CH_NUL);
    send_text("-1");
    put_char(CH_NUL);
    send_text("+");
    put_char(CH_NUL);
    send_text("\t 7x");
    send_char(CH_0 + 8'd5, 1'b0);
    send_text("3");
    send_text("8");
    put_char(8'hff);
    write_base(BASE_AUTO);
    send_text("0x");
    put_char(CH_NUL);
    send_text("017");
    put_char(8'hff);

    // a long string that overflows on the way
    write_base(BASE_DEC);
    send_text("1");
    repeat (LONG_DIGITS) put_char(CH_0);
    put_char(CH_NUL);

    rand_begin = chars_sent;
    k = 0;
    while (chars_sent - rand_begin < RANDOM_CHARS) begin
      if (k < 9) write_base(pick_base(k));
      else if ($urandom_range(0, 1)) write_base(pick_base($urandom_range(0, 8)));
      else write_base(BASE_BITS'($urandom_range(0, 63)));
      // long hold-off while characters keep coming
      if (k == 0) long_stall_req = 1'b1;
      phase_end = chars_sent + $urandom_range(40, 90);
      while (chars_sent < phase_end) begin
        send_number();
        if (chars_sent - rand_begin >= CALM_CHARS) calm = 1'b1;
      end
      k++;
    end

    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("ascii_to_unsigned_parser test passed");
    end else begin
      $display("ascii_to_unsigned_parser test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/atou_pkg.sv
hdl/atou_digit.sv
hdl/atou_core.sv
hdl/ascii_to_unsigned_parser.sv
test/atou_result_checker.sv
test/testbench.sv
